>>> hw/rtl/vgff_pkg.sv
// ----------------------------------------------------------------------------
// VFD grid frame formatter package
// Shared widths, beat layouts, operation codes, gray levels and the grid
// bit tables used by the frame formatter modules.
// ----------------------------------------------------------------------------
package vgff_pkg;

	localparam int unsigned FRAME_WIDTH_DEF  = 128;
	localparam int unsigned FRAME_HEIGHT_DEF = 32;

	localparam int unsigned PIX_W  = 2;
	localparam int unsigned WORD_W = 24;
	localparam int unsigned OFF_W  = 11;
	localparam int unsigned OP_W   = 3;

	// Input beat layout.
	localparam int unsigned IN_TDATA_W = 40;
	localparam int unsigned X_LSB      = 0;
	localparam int unsigned Y_LSB      = 7;
	localparam int unsigned WID_LSB    = 12;
	localparam int unsigned HGT_LSB    = 20;
	localparam int unsigned COLOR_LSB  = 26;
	localparam int unsigned GRID_LSB   = 28;

	// Output beat layout.
	localparam int unsigned OUT_TDATA_W = 64;
	localparam int unsigned PV_LSB      = 0;
	localparam int unsigned SIN1_LSB    = 2;
	localparam int unsigned SIN2_LSB    = 26;
	localparam int unsigned BOFF_LSB    = 50;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE   = 3'd0,
		OP_READ    = 3'd1,
		OP_FILL    = 3'd2,
		OP_RECT    = 3'd3,
		OP_OUTLINE = 3'd4,
		OP_EMIT    = 3'd5
	} op_t;

	localparam logic [PIX_W-1:0] PIX_FULL = 2'd0;
	localparam logic [PIX_W-1:0] PIX_TWO  = 2'd1;
	localparam logic [PIX_W-1:0] PIX_ONE  = 2'd2;
	localparam logic [PIX_W-1:0] PIX_OFF  = 2'd3;

	// Tag that follows a frame read to the stage where its data returns.
	typedef struct packed {
		logic       valid;
		logic       is_read;
		logic       inframe;
		logic       odd;
		logic [3:0] idx;
		logic       group_end;
		logic [2:0] group;
	} tag_t;

	// Drive bit of a pixel at position (row % 4) * 3 + column in grid.
	function automatic logic [WORD_W-1:0] grid_bit(input logic odd, input logic [3:0] idx);
		logic [WORD_W-1:0] b;
		b = '0;
		if (!odd) begin
			case (idx)
				4'd0:    b = 24'h800000;
				4'd1:    b = 24'h200000;
				4'd2:    b = 24'h080000;
				4'd3:    b = 24'h020000;
				4'd4:    b = 24'h008000;
				4'd5:    b = 24'h002000;
				4'd6:    b = 24'h000800;
				4'd7:    b = 24'h000200;
				4'd8:    b = 24'h000080;
				4'd9:    b = 24'h000020;
				4'd10:   b = 24'h000008;
				4'd11:   b = 24'h000002;
				default: b = '0;
			endcase
		end else begin
			case (idx)
				4'd0:    b = 24'h040000;
				4'd1:    b = 24'h100000;
				4'd2:    b = 24'h400000;
				4'd3:    b = 24'h001000;
				4'd4:    b = 24'h004000;
				4'd5:    b = 24'h010000;
				4'd6:    b = 24'h000040;
				4'd7:    b = 24'h000100;
				4'd8:    b = 24'h000400;
				4'd9:    b = 24'h000001;
				4'd10:   b = 24'h000004;
				4'd11:   b = 24'h000010;
				default: b = '0;
			endcase
		end
		return b;
	endfunction

endpackage

>>> hw/rtl/vfd_grid_frame_formatter_top.sv
// ----------------------------------------------------------------------------
// VFD grid frame formatter
// Frame memory with pixel, fill and rectangle drawing, and a grid formatter
// that turns three frame columns into eight pairs of 24-bit drive words.
// ----------------------------------------------------------------------------
// After reset the block sweeps the frame to off, one pixel a cycle, with
// s_axis_tready low. Every operation then runs on the single frame memory
// port after the beat is taken: write pixel and read pixel touch one pixel,
// fill frame walks the whole frame, fill rectangle and outline walk the
// rectangle clipped to the frame, one pixel a cycle, and emit grid makes its
// 96 pixel reads one a cycle; read pixel and emit grid hold while the output
// keeps a previous result. Results go to an output register, so the next
// beat is taken while a result still waits. Ops 6 and 7 are dropped without
// result.
module vfd_grid_frame_formatter_top #(
	parameter int unsigned FRAME_WIDTH  = vgff_pkg::FRAME_WIDTH_DEF,
	parameter int unsigned FRAME_HEIGHT = vgff_pkg::FRAME_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// x[6:0], y[11:7], width[19:12], height[25:20], color[27:26], grid[33:28]
	input  logic [vgff_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// op[2:0]
	input  logic [vgff_pkg::OP_W-1:0]        s_axis_tuser,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// pixel_value[1:0], sin1_word[25:2], sin2_word[49:26], byte_offset[60:50]
	output logic [vgff_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                             m_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready
);
	import vgff_pkg::*;

	localparam int unsigned DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned XW    = $clog2(FRAME_WIDTH);
	localparam int unsigned YW    = $clog2(FRAME_HEIGHT);
	localparam logic [8:0]  FW9   = 9'(FRAME_WIDTH);
	localparam logic [6:0]  FH7   = 7'(FRAME_HEIGHT);
	localparam logic [XW-1:0] X_LAST = XW'(FRAME_WIDTH - 1);
	localparam logic [YW-1:0] Y_LAST = YW'(FRAME_HEIGHT - 1);
	localparam logic [1:0]  GCOL_LAST = 2'd2;
	localparam logic [1:0]  GROW_LAST = 2'd3;
	localparam logic [2:0]  GROUP_LAST = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_RECT,
		ST_EMIT
	} state_t;

	// Beat fields.
	op_t              in_op;
	logic [6:0]       in_x;
	logic [4:0]       in_y;
	logic [7:0]       in_w;
	logic [5:0]       in_h;
	logic [PIX_W-1:0] in_color;
	logic [5:0]       in_grid;

	assign in_op    = op_t'(s_axis_tuser);
	assign in_x     = s_axis_tdata[X_LSB +: 7];
	assign in_y     = s_axis_tdata[Y_LSB +: 5];
	assign in_w     = s_axis_tdata[WID_LSB +: 8];
	assign in_h     = s_axis_tdata[HGT_LSB +: 6];
	assign in_color = s_axis_tdata[COLOR_LSB +: PIX_W];
	assign in_grid  = s_axis_tdata[GRID_LSB +: 6];

	state_t           state_q;
	logic [6:0]       x_q;
	logic [4:0]       y_q;
	logic             px_in_q;
	logic [PIX_W-1:0] color_q;
	logic             outline_q;
	logic [XW-1:0]    ci_q;
	logic [YW-1:0]    cj_q;
	logic [XW-1:0]    x0_q;
	logic [XW-1:0]    ce_q;
	logic [YW-1:0]    re_q;
	logic [8:0]       xr_q;
	logic [6:0]       yb_q;
	logic             odd_q;
	logic [7:0]       gcol_q;
	logic [OFF_W-1:0] off_base_q;
	logic [2:0]       eg_q;
	logic [1:0]       er_q;
	logic [1:0]       ec_q;
	tag_t             tag_s1;
	logic             out_valid_q;
	logic [PIX_W-1:0] out_pix_q;
	logic [WORD_W-1:0] out_sin1_q;
	logic [WORD_W-1:0] out_sin2_q;
	logic [OFF_W-1:0] out_off_q;
	logic             out_last_q;

	// Rectangle setup from the beat.
	logic [8:0] xend;
	logic [6:0] yend;
	logic       rect_empty;
	logic       in_px_in;
	logic       in_fill;

	assign xend       = 9'(in_x) + 9'(in_w);
	assign yend       = 7'(in_y) + 7'(in_h);
	assign in_px_in   = (9'(in_x) < FW9) && (7'(in_y) < FH7);
	assign rect_empty = (in_w == '0) || (in_h == '0) || !in_px_in;
	assign in_fill    = (in_op == OP_FILL);

	// Memory port control.
	logic             mem_we;
	logic             mem_re;
	logic [AW-1:0]    mem_addr;
	logic [PIX_W-1:0] mem_rdata;
	logic [XW-1:0]    col_sel;
	logic [YW-1:0]    row_sel;
	logic [7:0]       ecol;
	logic [4:0]       erow;
	logic             e_in;
	logic             grp_end;
	logic             border;
	logic             out_free;
	logic             out_load;
	tag_t             tag_d;
	logic [WORD_W-1:0] pk_sin1;
	logic [WORD_W-1:0] pk_sin2;

	assign ecol     = gcol_q + 8'(ec_q);
	assign erow     = {eg_q, er_q};
	assign e_in     = (9'(ecol) < FW9) && (7'(erow) < FH7);
	assign grp_end  = (er_q == GROW_LAST) && (ec_q == GCOL_LAST);
	assign out_free = !out_valid_q || m_axis_tready;
	assign border   = (ci_q == x0_q) || (9'(ci_q) == xr_q) ||
	                  (7'(cj_q) == 7'(y_q)) || (7'(cj_q) == yb_q);

	always_comb begin
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		col_sel = ci_q;
		row_sel = cj_q;
		unique case (state_q)
			ST_WRITE: begin
				col_sel = px_in_q ? XW'(x_q) : '0;
				row_sel = px_in_q ? YW'(y_q) : '0;
				mem_we  = px_in_q;
			end
			ST_READ: begin
				col_sel = px_in_q ? XW'(x_q) : '0;
				row_sel = px_in_q ? YW'(y_q) : '0;
				mem_re  = out_free;
			end
			ST_RECT: mem_we = !outline_q || border;
			ST_EMIT: begin
				col_sel = e_in ? XW'(ecol) : '0;
				row_sel = e_in ? YW'(erow) : '0;
				// The last read of a group waits until the output register is free.
				mem_re  = !grp_end || out_free;
			end
			default: ;
		endcase
	end

	assign mem_addr = AW'(32'(row_sel) * 32'(FRAME_WIDTH) + 32'(col_sel));

	always_comb begin
		tag_d           = '0;
		tag_d.valid     = mem_re;
		tag_d.is_read   = (state_q == ST_READ);
		tag_d.inframe   = (state_q == ST_READ) ? px_in_q : e_in;
		tag_d.odd       = odd_q;
		tag_d.idx       = 4'(er_q) * 4'd3 + 4'(ec_q);
		tag_d.group_end = grp_end;
		tag_d.group     = eg_q;
	end

	assign out_load = tag_s1.valid && (tag_s1.is_read || tag_s1.group_end);

	vgff_frame_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (color_q),
		.rdata (mem_rdata)
	);

	vgff_grid_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.tag    (tag_s1),
		.pixel  (mem_rdata),
		.sin1   (pk_sin1),
		.sin2   (pk_sin2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// Reset starts a sweep that sets every pixel to off.
			state_q     <= ST_RECT;
			x_q         <= '0;
			y_q         <= '0;
			px_in_q     <= 1'b0;
			color_q     <= PIX_OFF;
			outline_q   <= 1'b0;
			ci_q        <= '0;
			cj_q        <= '0;
			x0_q        <= '0;
			ce_q        <= X_LAST;
			re_q        <= Y_LAST;
			xr_q        <= '0;
			yb_q        <= '0;
			odd_q       <= 1'b0;
			gcol_q      <= '0;
			off_base_q  <= '0;
			eg_q        <= '0;
			er_q        <= '0;
			ec_q        <= '0;
			tag_s1      <= '0;
			out_valid_q <= 1'b0;
			out_pix_q   <= '0;
			out_sin1_q  <= '0;
			out_sin2_q  <= '0;
			out_off_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			tag_s1 <= tag_d;

			if (out_load) begin
				out_valid_q <= 1'b1;
				if (tag_s1.is_read) begin
					out_pix_q  <= tag_s1.inframe ? mem_rdata : PIX_OFF;
					out_sin1_q <= '0;
					out_sin2_q <= '0;
					out_off_q  <= '0;
					out_last_q <= 1'b1;
				end else begin
					out_pix_q  <= '0;
					out_sin1_q <= pk_sin1;
					out_sin2_q <= pk_sin2;
					out_off_q  <= off_base_q + OFF_W'(tag_s1.group) * 11'd3;
					out_last_q <= (tag_s1.group == GROUP_LAST);
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						x_q        <= in_x;
						y_q        <= in_y;
						px_in_q    <= in_px_in;
						color_q    <= in_color;
						odd_q      <= in_grid[0];
						gcol_q     <= 8'(in_grid) * 8'd3;
						off_base_q <= OFF_W'(in_grid) * 11'd30;
						eg_q       <= '0;
						er_q       <= '0;
						ec_q       <= '0;
						// A frame fill walks the whole frame as one rectangle.
						ci_q       <= in_fill ? '0 : XW'(in_x);
						cj_q       <= in_fill ? '0 : YW'(in_y);
						x0_q       <= in_fill ? '0 : XW'(in_x);
						ce_q       <= (in_fill || (xend > FW9)) ? X_LAST : XW'(xend - 9'd1);
						re_q       <= (in_fill || (yend > FH7)) ? Y_LAST : YW'(yend - 7'd1);
						xr_q       <= xend - 9'd1;
						yb_q       <= yend - 7'd1;
						outline_q  <= (in_op == OP_OUTLINE);
						case (in_op) inside
							OP_WRITE: state_q <= ST_WRITE;
							OP_READ:  state_q <= ST_READ;
							OP_FILL:  state_q <= ST_RECT;
							OP_RECT, OP_OUTLINE: begin
								if (!rect_empty) begin
									state_q <= ST_RECT;
								end
							end
							OP_EMIT:  state_q <= ST_EMIT;
							default:  ;
						endcase
					end
				end
				ST_WRITE: state_q <= ST_IDLE;
				ST_READ: begin
					if (mem_re) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RECT: begin
					if (ci_q == ce_q) begin
						ci_q <= x0_q;
						if (cj_q == re_q) begin
							state_q <= ST_IDLE;
						end else begin
							cj_q <= cj_q + 1'b1;
						end
					end else begin
						ci_q <= ci_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (mem_re) begin
						if (ec_q == GCOL_LAST) begin
							ec_q <= '0;
							if (er_q == GROW_LAST) begin
								er_q <= '0;
								eg_q <= eg_q + 1'b1;
								if (eg_q == GROUP_LAST) begin
									state_q <= ST_IDLE;
								end
							end else begin
								er_q <= er_q + 1'b1;
							end
						end else begin
							ec_q <= ec_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {3'b000, out_off_q, out_sin2_q, out_sin1_q, out_pix_q};

	// A new result never lands on one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result register overwritten while full");

	// Frame writes stay inside the frame.
	a_write_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((32'(row_sel) < FRAME_HEIGHT) && (32'(col_sel) < FRAME_WIDTH)))
		else $error("frame write outside the frame");

	// The sequencer never reads and writes the frame in one cycle.
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("frame read and write in the same cycle");

	// An emit beat keeps the input closed while its groups are read.
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && (in_op == OP_EMIT)) |=> !s_axis_tready)
		else $error("input reopened during grid emit");

endmodule

>>> hw/rtl/vgff_frame_ram.sv
// ----------------------------------------------------------------------------
// Frame memory
// One shared port for writes and reads with registered read data, holding
// one 2-bit gray level per pixel.
// ----------------------------------------------------------------------------
module vgff_frame_ram #(
	parameter int unsigned DEPTH = vgff_pkg::FRAME_WIDTH_DEF * vgff_pkg::FRAME_HEIGHT_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic                       re,
	input  logic [AW-1:0]              addr,
	input  logic [vgff_pkg::PIX_W-1:0] wdata,
	output logic [vgff_pkg::PIX_W-1:0] rdata
);
	import vgff_pkg::*;

	logic [PIX_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

>>> hw/rtl/vgff_grid_packer.sv
// ----------------------------------------------------------------------------
// Grid word packer
// Folds one returned pixel per cycle, while grid reads arrive, into the drive
// word pair of the current row group, and starts over after its last pixel.
// ----------------------------------------------------------------------------
module vgff_grid_packer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vgff_pkg::tag_t              tag,
	input  logic [vgff_pkg::PIX_W-1:0]  pixel,
	output logic [vgff_pkg::WORD_W-1:0] sin1,
	output logic [vgff_pkg::WORD_W-1:0] sin2
);
	import vgff_pkg::*;

	logic [WORD_W-1:0] sin1_q;
	logic [WORD_W-1:0] sin2_q;
	logic [WORD_W-1:0] bit_sel;
	logic [PIX_W-1:0]  level;

	always_comb begin
		bit_sel = grid_bit(tag.odd, tag.idx);
		level   = tag.inframe ? pixel : PIX_OFF;
		sin1    = sin1_q;
		sin2    = sin2_q;
		case (level)
			PIX_FULL: begin
				sin1 = sin1_q | bit_sel;
				sin2 = sin2_q | bit_sel;
			end
			PIX_TWO: sin2 = sin2_q | bit_sel;
			PIX_ONE: sin1 = sin1_q | bit_sel;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sin1_q <= '0;
			sin2_q <= '0;
		end else if (tag.valid && !tag.is_read) begin
			sin1_q <= tag.group_end ? '0 : sin1;
			sin2_q <= tag.group_end ? '0 : sin2;
		end
	end

endmodule

>>> sim/vfd_grid_frame_formatter_top_tb.sv
// ----------------------------------------------------------------------------
// VFD grid frame formatter testbench
// Drives pixel, fill, rectangle and emit-grid beats into the formatter and
// keeps a shadow copy of the frame. Read and emit beats are predicted from
// that copy, and every output beat is checked field by field in order. Both
// stream sides idle at random, with one long output hold-off and three drains.
// ----------------------------------------------------------------------------
module vfd_grid_frame_formatter_top_tb;
	import vgff_pkg::*;

	localparam int FW          = FRAME_WIDTH_DEF;
	localparam int FH          = FRAME_HEIGHT_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 150;

	// Op codes the block does not implement; they must be dropped silently.
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef struct {
		logic [PIX_W-1:0]  pixel;
		logic [WORD_W-1:0] sin1;
		logic [WORD_W-1:0] sin2;
		logic [OFF_W-1:0]  offset;
		logic              last;
	} drive_beat_t;

	logic                   clk;
	logic                   arst_n;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [OP_W-1:0]        s_axis_tuser;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;

	logic [PIX_W-1:0] frame_shadow [0:FW*FH-1];
	drive_beat_t      expected_beats [$];
	int               errors = 0;
	int               rx_hold_cycles = 0;
	bit               no_idle = 1'b0;

	vfd_grid_frame_formatter_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles, %0d beats outstanding",
					cycles, expected_beats.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Shadow frame access. Anything outside the frame reads as off.
	function automatic logic [PIX_W-1:0] shadow_get(int px, int py);
		if (px < FW && py < FH)
			return frame_shadow[py*FW + px];
		return PIX_OFF;
	endfunction

	function automatic void shadow_put(int px, int py, logic [PIX_W-1:0] c);
		if (px < FW && py < FH)
			frame_shadow[py*FW + px] = c;
	endfunction

	// Applies one accepted beat to the shadow frame and queues the beats it yields.
	function automatic void predict_frame_op(logic [OP_W-1:0] op, int x, int y, int w,
			int h, logic [PIX_W-1:0] color, int grid);
		drive_beat_t       beat;
		logic [WORD_W-1:0] s1;
		logic [WORD_W-1:0] s2;
		logic [PIX_W-1:0]  p;
		int                pos;
		int                offs;
		case (op)
			OP_WRITE: shadow_put(x, y, color);
			OP_READ: begin
				beat = '{shadow_get(x, y), '0, '0, '0, 1'b1};
				expected_beats.push_back(beat);
			end
			OP_FILL: begin
				for (int i = 0; i < FW*FH; i++)
					frame_shadow[i] = color;
			end
			OP_RECT: begin
				for (int j = 0; j < h; j++)
					for (int i = 0; i < w; i++)
						shadow_put(x + i, y + j, color);
			end
			OP_OUTLINE: begin
				if (w != 0 && h != 0) begin
					for (int i = 0; i < w; i++) begin
						shadow_put(x + i, y, color);
						shadow_put(x + i, y + h - 1, color);
					end
					for (int j = 0; j < h; j++) begin
						shadow_put(x, y + j, color);
						shadow_put(x + w - 1, y + j, color);
					end
				end
			end
			OP_EMIT: begin
				for (int g = 0; g < 8; g++) begin
					s1 = '0;
					s2 = '0;
					for (int r = 0; r < 4; r++) begin
						for (int c = 0; c < 3; c++) begin
							// Even grids walk down from bit 23 in steps of two; odd grids
							// fill bits 18..22, 12..16, 6..10 and 0..4, one row a run.
							pos = grid[0] ? 18 - 6*r + 2*c : 23 - 6*r - 2*c;
							p = shadow_get(grid*3 + c, g*4 + r);
							if (p == PIX_FULL || p == PIX_ONE)
								s1[pos] = 1'b1;
							if (p == PIX_FULL || p == PIX_TWO)
								s2[pos] = 1'b1;
						end
					end
					offs = grid*30 + g*3;
					beat = '{'0, s1, s2, offs[OFF_W-1:0], g == 7};
					expected_beats.push_back(beat);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			errors++;
		end
	endtask

	initial begin : drive_word_monitor
		drive_beat_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: output beat with nothing expected, actual tdata 0x%0h",
						$time, m_axis_tdata);
					errors++;
				end else begin
					want = expected_beats.pop_front();
					check_field("pixel_value", 32'(want.pixel),
						32'(m_axis_tdata[PV_LSB +: PIX_W]));
					check_field("sin1_word", 32'(want.sin1),
						32'(m_axis_tdata[SIN1_LSB +: WORD_W]));
					check_field("sin2_word", 32'(want.sin2),
						32'(m_axis_tdata[SIN2_LSB +: WORD_W]));
					check_field("byte_offset", 32'(want.offset),
						32'(m_axis_tdata[BOFF_LSB +: OFF_W]));
					check_field("tlast", 32'(want.last), 32'(m_axis_tlast));
				end
			end
		end
	end

	// Output ready: short random stalls, plus a long hold when a test asks.
	initial begin : ready_driver
		int stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 3);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_beat(logic [OP_W-1:0] op, logic [6:0] x, logic [4:0] y,
			logic [7:0] w, logic [5:0] h, logic [PIX_W-1:0] color, logic [5:0] grid);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tdata  <= {6'd0, grid, color, h, w, y, x};
		s_axis_tuser  <= op;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_frame_op(op, int'(x), int'(y), int'(w), int'(h), color, int'(grid));
	endtask

	// Waits on the clock before the first check, so the next beat drives on a new edge.
	task automatic wait_for_all_results();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (expected_beats.size() != 0);
	endtask

	// Random beat. Drawing is kept mostly to the first grids so that the emits
	// see real content; fields that an op ignores still get random values.
	task automatic send_random_beat();
		logic [OP_W-1:0]  op;
		logic [6:0]       x;
		logic [4:0]       y;
		logic [7:0]       w;
		logic [5:0]       h;
		logic [5:0]       grid;
		logic [PIX_W-1:0] color;
		int               pick;
		pick  = $urandom_range(0, 99);
		x     = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) :
		                                      7'($urandom_range(0, 17));
		y     = 5'($urandom_range(0, 31));
		w     = 8'($urandom_range(0, 255));
		h     = 6'($urandom_range(0, 63));
		grid  = 6'($urandom_range(0, 63));
		color = PIX_W'($urandom_range(0, 3));
		if (pick < 18)
			op = OP_WRITE;
		else if (pick < 36)
			op = OP_READ;
		else if (pick < 60) begin
			op = OP_EMIT;
			if ($urandom_range(0, 4) != 0)
				grid = 6'($urandom_range(0, 5));
		end else if (pick < 90) begin
			op = (pick < 76) ? OP_RECT : OP_OUTLINE;
			if ($urandom_range(0, 9) != 0) begin
				w = 8'($urandom_range(0, 10));
				h = 6'($urandom_range(0, 6));
			end
		end else if (pick < 93)
			op = OP_FILL;
		else
			op = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
		send_beat(op, x, y, w, h, color, grid);
	endtask

	task automatic test_reset_state();
		send_beat(OP_READ, 7'd0, 5'd0, 8'd0, 6'd0, PIX_FULL, 6'd0);
		send_beat(OP_READ, 7'd127, 5'd31, 8'd255, 6'd63, PIX_FULL, 6'd63);
		send_beat(OP_EMIT, 7'd0, 5'd0, 8'd0, 6'd0, PIX_FULL, 6'd0);
	endtask

	task automatic test_pixel_access();
		send_beat(OP_WRITE, 7'd0, 5'd0, 8'd0, 6'd0, PIX_FULL, 6'd0);
		send_beat(OP_WRITE, 7'd1, 5'd0, 8'd0, 6'd0, PIX_TWO, 6'd0);
		send_beat(OP_WRITE, 7'd2, 5'd5, 8'd0, 6'd0, PIX_ONE, 6'd0);
		send_beat(OP_WRITE, 7'd127, 5'd31, 8'd0, 6'd0, PIX_FULL, 6'd0);
		send_beat(OP_WRITE, 7'd126, 5'd30, 8'd0, 6'd0, PIX_ONE, 6'd0);
		send_beat(OP_READ, 7'd1, 5'd0, 8'd0, 6'd0, PIX_OFF, 6'd0);
		send_beat(OP_READ, 7'd2, 5'd5, 8'd0, 6'd0, PIX_OFF, 6'd0);
		send_beat(OP_READ, 7'd127, 5'd31, 8'd0, 6'd0, PIX_OFF, 6'd0);
	endtask

	// Even and odd grids, the two-column last grid and grids past the frame.
	task automatic test_emit_edges();
		send_beat(OP_WRITE, 7'd3, 5'd1, 8'd0, 6'd0, PIX_FULL, 6'd0);
		send_beat(OP_EMIT, 7'd0, 5'd0, 8'd0, 6'd0, PIX_FULL, 6'd0);
		send_beat(OP_EMIT, 7'd0, 5'd0, 8'd0, 6'd0, PIX_FULL, 6'd1);
		send_beat(OP_EMIT, 7'd0, 5'd0, 8'd0, 6'd0, PIX_FULL, 6'd42);
		send_beat(OP_EMIT, 7'd0, 5'd0, 8'd0, 6'd0, PIX_FULL, 6'd43);
		send_beat(OP_EMIT, 7'd0, 5'd0, 8'd0, 6'd0, PIX_FULL, 6'd63);
	endtask

	// Clipped rectangles, empty outlines and an outline running off the frame.
	task automatic test_rectangles();
		send_beat(OP_RECT, 7'd120, 5'd28, 8'd255, 6'd63, PIX_TWO, 6'd0);
		send_beat(OP_RECT, 7'd4, 5'd4, 8'd0, 6'd5, PIX_FULL, 6'd0);
		send_beat(OP_OUTLINE, 7'd5, 5'd5, 8'd0, 6'd4, PIX_FULL, 6'd0);
		send_beat(OP_OUTLINE, 7'd5, 5'd5, 8'd4, 6'd0, PIX_FULL, 6'd0);
		send_beat(OP_OUTLINE, 7'd2, 5'd2, 8'd128, 6'd32, PIX_ONE, 6'd0);
		send_beat(OP_EMIT, 7'd0, 5'd0, 8'd0, 6'd0, PIX_FULL, 6'd42);
	endtask

	task automatic test_fill_and_unused();
		send_beat(OP_FILL, 7'd0, 5'd0, 8'd0, 6'd0, PIX_FULL, 6'd0);
		send_beat(OP_SPARE_LO, 7'd9, 5'd9, 8'd9, 6'd9, PIX_OFF, 6'd9);
		send_beat(OP_SPARE_HI, 7'd9, 5'd9, 8'd9, 6'd9, PIX_OFF, 6'd9);
		send_beat(OP_EMIT, 7'd0, 5'd0, 8'd0, 6'd0, PIX_FULL, 6'd10);
		send_beat(OP_FILL, 7'd0, 5'd0, 8'd0, 6'd0, PIX_OFF, 6'd0);
	endtask

	// The output is held off while emits keep coming, so the input must stall.
	task automatic test_backpressure();
		wait_for_all_results();
		rx_hold_cycles = 400;
		for (int i = 0; i < 6; i++)
			send_beat(OP_EMIT, 7'd0, 5'd0, 8'd0, 6'd0, PIX_FULL, 6'($urandom_range(0, 5)));
		for (int i = 0; i < 4; i++)
			send_random_beat();
	endtask

	task automatic test_random_mix();
		for (int i = 0; i < 80; i++) begin
			if (i == 40)
				wait_for_all_results();
			send_random_beat();
		end
	endtask

	task automatic test_steady_tail();
		no_idle = 1'b1;
		for (int i = 0; i < 30; i++)
			send_random_beat();
	endtask

	initial begin
		for (int i = 0; i < FW*FH; i++)
			frame_shadow[i] = PIX_OFF;
		arst_n        = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		s_axis_tvalid = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_pixel_access();
		test_emit_edges();
		test_rectangles();
		test_fill_and_unused();
		test_backpressure();
		test_random_mix();
		test_steady_tail();

		wait_for_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/vgff_pkg.sv
hw/rtl/vgff_frame_ram.sv
hw/rtl/vgff_grid_packer.sv
hw/rtl/vfd_grid_frame_formatter_top.sv
sim/vfd_grid_frame_formatter_top_tb.sv
